// File: hw/rtl/pfc_pkg.sv
package pfc_pkg;

	localparam logic [2:0] FMT_XRGB8888    = 3'd0;
	localparam logic [2:0] FMT_ARGB8888    = 3'd1;
	localparam logic [2:0] FMT_XRGB2101010 = 3'd2;
	localparam logic [2:0] FMT_XBGR2101010 = 3'd3;
	localparam logic [2:0] FMT_GRAY8       = 3'd4;

	localparam logic [0:0] REG_SOURCE_FORMAT = 1'b0;
	localparam logic [0:0] REG_TARGET_FORMAT = 1'b1;

	localparam int CH_W   = 10;
	localparam int PROD_W = 26;
	localparam int WSUM_W = 18;

	localparam logic [PROD_W-1:0] LUMA_WR = 26'd13933;
	localparam logic [PROD_W-1:0] LUMA_WG = 26'd46871;
	localparam logic [PROD_W-1:0] LUMA_WB = 26'd4732;

	localparam logic [CH_W:0] MAX10 = 11'd1023;

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} luma_en_t;

endpackage

// File: hw/rtl/pfc_luma.sv
module pfc_luma
	import pfc_pkg::*;
(
	input  logic     clk,
	input  luma_en_t en,
	input  chan_t    r,
	input  chan_t    g,
	input  chan_t    b,
	input  logic     src10,
	output logic [7:0] gray
);

	logic [PROD_W-1:0] pr_s2, pg_s2, pb_s2;
	logic              src10_s2, src10_s3, src10_s4;
	logic [PROD_W-1:0] sum_s3;
	logic [WSUM_W-1:0] w_s4;
	logic [PROD_W+7:0] scaled;
	logic [7:0]        q;
	logic [CH_W-1:0]   f;
	logic [CH_W:0]     qf;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pr_s2    <= LUMA_WR * {16'b0, r};
			pg_s2    <= LUMA_WG * {16'b0, g};
			pb_s2    <= LUMA_WB * {16'b0, b};
			src10_s2 <= src10;
		end
		if (en.s3) begin
			sum_s3   <= pr_s2 + pg_s2 + pb_s2;
			src10_s3 <= src10_s2;
		end
		if (en.s4) begin
			w_s4     <= src10_s3 ? scaled[PROD_W+7:16] : {10'b0, sum_s3[23:16]};
			src10_s4 <= src10_s3;
		end
	end

	// sum * 255 as shift and subtract
	assign scaled = {sum_s3, 8'b0} - {8'b0, sum_s3};

	// w / 1023 = q + (q + f >= 1023) with q = w >> 10, f = w mod 1024
	assign q  = w_s4[WSUM_W-1:10];
	assign f  = w_s4[9:0];
	assign qf = {3'b0, q} + {1'b0, f};

	assign gray = src10_s4 ? q + {7'b0, qf >= MAX10} : w_s4[7:0];

endmodule

// File: hw/rtl/pixel_format_converter_unit.sv
// Pixel format converter.
// Pipeline: an accepted input transaction passes through registers s1 to s5 before dst_valid.
// Throughput: one pixel per clock while dst_stall is low; bubbles are squeezed out under stall.
// The luma path (multiply, sum, scale, divide) sets the pipeline depth.
// Reset: arst_n clears valid bits and both format registers (XRGB8888).
module pixel_format_converter_unit
	import pfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [31:0] pixel_in,
	output logic        dst_valid,
	input  logic        dst_stall,
	output logic [31:0] pixel_out
);

	logic [2:0] source_format_q, target_format_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	chan_t      r_d, g_d, b_d;
	logic [7:0] a_d;
	logic       src10_d;

	chan_t      r_s1, g_s1, b_s1;
	logic [7:0] a_s1, a_s2, a_s3, a_s4;
	logic       src10_s1;
	logic [2:0] tgt_s1, tgt_s2, tgt_s3, tgt_s4;
	chan_t      r_s2, g_s2, b_s2, r_s3, g_s3, b_s3, r_s4, g_s4, b_s4;
	logic       tgt10;
	logic [7:0] gray;
	luma_en_t   luma_en;

	function automatic chan_t up10(input logic [7:0] v);
		logic [1:0] d;
		d = (v == 8'd255) ? 2'd3 : (v >= 8'd170) ? 2'd2 : (v >= 8'd85) ? 2'd1 : 2'd0;
		return {v, 2'b00} + {8'b0, d};
	endfunction

	// floor(v*255/1023) = (v >> 2) or one less
	function automatic logic [7:0] down8(input chan_t v);
		logic dec;
		dec = (v[1:0] == 2'd0 && v != 10'd0) || (v[1:0] == 2'd1 && v > 10'd341)
			|| (v[1:0] == 2'd2 && v > 10'd682);
		return v[9:2] - {7'b0, dec};
	endfunction

	function automatic chan_t rescale(input chan_t v, input logic s10, input logic t10);
		if (s10 == t10)
			return v;
		else if (t10)
			return up10(v[7:0]);
		else
			return {2'b0, down8(v)};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= FMT_XRGB8888;
			target_format_q <= FMT_XRGB8888;
		end else if (cfg_we && cfg_index[1] == 1'b0) begin
			if (cfg_index[0] == REG_SOURCE_FORMAT)
				source_format_q <= cfg_data;
			else
				target_format_q <= cfg_data;
		end
	end

	assign rdy5 = !v_s5 || !dst_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign src_stall = !rdy1;
	assign dst_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= src_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		a_d     = 8'hff;
		src10_d = 1'b0;
		r_d     = {2'b0, pixel_in[23:16]};
		g_d     = {2'b0, pixel_in[15:8]};
		b_d     = {2'b0, pixel_in[7:0]};
		unique case (source_format_q)
			FMT_ARGB8888: begin
				a_d = pixel_in[31:24];
			end
			FMT_XRGB2101010: begin
				src10_d = 1'b1;
				r_d     = pixel_in[29:20];
				g_d     = pixel_in[19:10];
				b_d     = pixel_in[9:0];
			end
			FMT_XBGR2101010: begin
				src10_d = 1'b1;
				b_d     = pixel_in[29:20];
				g_d     = pixel_in[19:10];
				r_d     = pixel_in[9:0];
			end
			FMT_GRAY8: begin
				r_d = {2'b0, pixel_in[7:0]};
				g_d = {2'b0, pixel_in[7:0]};
				b_d = {2'b0, pixel_in[7:0]};
			end
			default: begin
			end
		endcase
	end

	assign tgt10 = (tgt_s1 == FMT_XRGB2101010) || (tgt_s1 == FMT_XBGR2101010);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			r_s1     <= r_d;
			g_s1     <= g_d;
			b_s1     <= b_d;
			a_s1     <= a_d;
			src10_s1 <= src10_d;
			tgt_s1   <= target_format_q;
		end
		if (rdy2) begin
			r_s2   <= rescale(r_s1, src10_s1, tgt10);
			g_s2   <= rescale(g_s1, src10_s1, tgt10);
			b_s2   <= rescale(b_s1, src10_s1, tgt10);
			a_s2   <= a_s1;
			tgt_s2 <= tgt_s1;
		end
		if (rdy3) begin
			r_s3   <= r_s2;
			g_s3   <= g_s2;
			b_s3   <= b_s2;
			a_s3   <= a_s2;
			tgt_s3 <= tgt_s2;
		end
		if (rdy4) begin
			r_s4   <= r_s3;
			g_s4   <= g_s3;
			b_s4   <= b_s3;
			a_s4   <= a_s3;
			tgt_s4 <= tgt_s3;
		end
		if (rdy5) begin
			unique case (tgt_s4)
				FMT_XRGB8888:    pixel_out <= {8'b0, r_s4[7:0], g_s4[7:0], b_s4[7:0]};
				FMT_ARGB8888:    pixel_out <= {a_s4, r_s4[7:0], g_s4[7:0], b_s4[7:0]};
				FMT_XRGB2101010: pixel_out <= {2'b0, r_s4, g_s4, b_s4};
				FMT_XBGR2101010: pixel_out <= {2'b0, b_s4, g_s4, r_s4};
				FMT_GRAY8:       pixel_out <= {24'b0, gray};
				default:         pixel_out <= 32'b0;
			endcase
		end
	end

	assign luma_en.s2 = rdy2;
	assign luma_en.s3 = rdy3;
	assign luma_en.s4 = rdy4;

	pfc_luma u_luma (
		.clk   (clk),
		.en    (luma_en),
		.r     (r_s1),
		.g     (g_s1),
		.b     (b_s1),
		.src10 (src10_s1),
		.gray  (gray)
	);

endmodule
